@@ hdl/jddm_pkg.sv @@
package jddm_pkg;

    localparam int AXIS_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 15;
    localparam int DZ_W          = 15;
    localparam int FS_W          = 8;
    localparam int SPD_W         = 8;
    localparam int MASK_W        = 8;
    localparam int BTN_W         = 9;
    // Dead zone compares are done with the radius shifted up by this many bits.
    localparam int DZ_SHIFT      = 15;

    localparam logic [DZ_W-1:0] STICK_DZ_RST   = 15'd1638;
    localparam logic [DZ_W-1:0] TWIST_DZ_RST   = 15'd1638;
    localparam logic [FS_W-1:0] FULL_SCALE_RST = 8'd100;

    // cos(pi/8) and sin(pi/8) in Q0.16, held signed for the cross products.
    localparam logic signed [17:0] COS8 = 18'sd60547;
    localparam logic signed [17:0] SIN8 = 18'sd25080;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STICK_DZ   = 2'd0,
        REG_TWIST_DZ   = 2'd1,
        REG_FULL_SCALE = 2'd2
    } t_cfg_reg;

    localparam int MB_ONE    = 0;
    localparam int MB_CENTER = 1;
    localparam int MB_LEFT   = 2;
    localparam int MB_RIGHT  = 3;
    localparam int MB_FLAG   = 7;

    localparam int BTN_FLAG   = 3;
    localparam int BTN_SPIN_L = 6;
    localparam int BTN_SPIN_R = 7;
    localparam int BTN_QUIT   = 8;

    // Per-report side information that rides along the square root pipeline.
    typedef struct packed {
        logic [BTN_W-1:0] btn;
        logic [SPD_W-1:0] center;
        logic             twist_rev;
        logic             y_pos;
        logic             fwd_left;
        logic             sec_right;
        logic             sec_both;
        logic             sec_left;
    } t_side;

endpackage

@@ hdl/jddm_rpt_if.sv @@
interface jddm_rpt_if
    import jddm_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [AXIS_BITS-1:0] axis_x;
    logic signed [AXIS_BITS-1:0] axis_y;
    logic signed [AXIS_BITS-1:0] axis_twist;
    logic [BTN_W-1:0]            button_bits;

    modport source (output valid, axis_x, axis_y, axis_twist, button_bits, input ready);
    modport sink   (input valid, axis_x, axis_y, axis_twist, button_bits, output ready);
endinterface

@@ hdl/jddm_mix_if.sv @@
interface jddm_mix_if
    import jddm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SPD_W-1:0]  left_speed;
    logic [SPD_W-1:0]  right_speed;
    logic [SPD_W-1:0]  center_speed;
    logic [MASK_W-1:0] direction_mask;
    logic              quit;

    modport source (output valid, left_speed, right_speed, center_speed, direction_mask, quit,
                    input ready);
    modport sink   (input valid, left_speed, right_speed, center_speed, direction_mask, quit,
                    output ready);
endinterface

@@ hdl/jddm_isqrt.sv @@
module jddm_isqrt
    import jddm_pkg::*;
#(
    parameter int N      = AXIS_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*N-1:0]    i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [N-1:0]      o_root,
    output logic [SIDE_W-1:0] o_side
);

    // One result bit per stage, restoring digit recurrence.
    logic              r_vld  [N];
    logic [2*N-1:0]    r_rad  [N];
    logic [N+1:0]      r_rem  [N];
    logic [N-1:0]      r_res  [N];
    logic [SIDE_W-1:0] r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic              p_vld;
        logic [2*N-1:0]    p_rad;
        logic [N+1:0]      p_rem;
        logic [N-1:0]      p_res;
        logic [SIDE_W-1:0] p_side;
        logic [N+1:0]      cur;
        logic [N+1:0]      trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_res  = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_res  = r_res[k-1];
            assign p_side = r_side[k-1];
        end

        assign cur   = {p_rem[N-1:0], p_rad[2*N-1:2*N-2]};
        assign trial = {p_res, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
            if (i_en) begin
                r_rad[k]  <= {p_rad[2*N-3:0], 2'b00};
                r_rem[k]  <= ge ? (cur - trial) : cur;
                r_res[k]  <= {p_res[N-2:0], ge};
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_res[N-1];
    assign o_side  = r_side[N-1];

endmodule

@@ hdl/joystick_differential_drive_mixer.sv @@
// Channel | Direction | Handshake     | Payload
// i_rpt   | in        | valid / ready | axis_x, axis_y, axis_twist, button_bits
// o_mix   | out       | valid / ready | left, right, center speed, direction_mask, quit
// i_cfg_* | in        | write enable  | register index, 15-bit data
//
// One report is taken per cycle while the output is not held. Most of the pipeline
// is the square root, which resolves one bit per stage.
// Reset is synchronous and active low; it empties the pipeline and loads the register
// defaults. When the output is held, every stage holds and i_rpt.ready drops, so no
// transaction is lost or repeated.
module joystick_differential_drive_mixer
    import jddm_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    jddm_rpt_if.sink              i_rpt,
    jddm_mix_if.source            o_mix
);

    localparam int N    = AXIS_BITS;
    localparam int FRAC = N - 1;
    localparam int XW   = N + 18;
    localparam int SW   = $bits(t_side);

    localparam logic [N-1:0] ONE = N'(1) << FRAC;

    // Configuration registers.
    logic [DZ_W-1:0] r_stick_dz;
    logic [DZ_W-1:0] r_twist_dz;
    logic [FS_W-1:0] r_full_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick_dz   <= STICK_DZ_RST;
            r_twist_dz   <= TWIST_DZ_RST;
            r_full_scale <= FULL_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_STICK_DZ:   r_stick_dz   <= i_cfg_data[DZ_W-1:0];
                REG_TWIST_DZ:   r_twist_dz   <= i_cfg_data[DZ_W-1:0];
                REG_FULL_SCALE: r_full_scale <= i_cfg_data[FS_W-1:0];
                default: ;
            endcase
        end
    end

    // Every stage moves together unless the output register is full and held.
    logic w_en;
    assign w_en        = !o_mix.valid || o_mix.ready;
    assign i_rpt.ready = w_en;

    // Stage 1: twist magnitude, twist times full scale and all of the products of the raw axes.
    logic signed [N-1:0] w_tw;
    logic [N-1:0]        w_tmag;

    assign w_tw   = i_rpt.axis_twist;
    assign w_tmag = w_tw[N-1] ? N'(-w_tw) : N'(w_tw);

    logic                r_s1_vld;
    logic signed [N-1:0] r_s1_x;
    logic signed [N-1:0] r_s1_y;
    logic [BTN_W-1:0]    r_s1_btn;
    logic                r_s1_tneg;
    logic [N-1:0]        r_s1_tmag;
    logic [N+7:0]        r_s1_tfs;
    logic signed [2*N-1:0] r_s1_xx;
    logic signed [2*N-1:0] r_s1_yy;
    logic signed [XW-1:0]  r_s1_yc;
    logic signed [XW-1:0]  r_s1_xs;
    logic signed [XW-1:0]  r_s1_ys;
    logic signed [XW-1:0]  r_s1_xc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_rpt.valid;
        end
        if (w_en) begin
            r_s1_x    <= i_rpt.axis_x;
            r_s1_y    <= i_rpt.axis_y;
            r_s1_btn  <= i_rpt.button_bits;
            r_s1_tneg <= w_tw[N-1];
            r_s1_tmag <= w_tmag;
            r_s1_tfs  <= w_tmag * r_full_scale;
            r_s1_xx   <= i_rpt.axis_x * i_rpt.axis_x;
            r_s1_yy   <= i_rpt.axis_y * i_rpt.axis_y;
            r_s1_yc   <= i_rpt.axis_y * COS8;
            r_s1_xs   <= i_rpt.axis_x * SIN8;
            r_s1_ys   <= i_rpt.axis_y * SIN8;
            r_s1_xc   <= i_rpt.axis_x * COS8;
        end
    end

    // Stage 2: radius squared, sector tests against the backward boundaries,
    // the forward mixing factor and the complete center motor result.
    logic signed [XW:0] w_d1, w_d3, w_d5, w_d7;
    logic               w_p1, w_p3, w_p5, w_p7;
    logic               w_tdz;
    logic               w_fwd_left;
    logic signed [N:0]  w_fac_s;
    t_side              n_side;

    assign w_d1 = r_s1_yc - r_s1_xs;
    assign w_d3 = r_s1_ys - r_s1_xc;
    assign w_d5 = r_s1_ys + r_s1_xc;
    assign w_d7 = r_s1_yc + r_s1_xs;
    assign w_p1 = (w_d1 > 0);
    assign w_p3 = (w_d3 > 0);
    assign w_p5 = (w_d5 < 0);
    assign w_p7 = (w_d7 < 0);

    assign w_tdz = ({r_s1_tmag, {DZ_SHIFT{1'b0}}}) < ((N + DZ_SHIFT)'(r_twist_dz) << FRAC);
    assign w_fwd_left = (r_s1_x > 0) || (r_s1_x == 0 && r_s1_y == 0);
    assign w_fac_s = w_fwd_left ? ($signed({1'b0, ONE}) - r_s1_x)
                                : ($signed({1'b0, ONE}) + r_s1_x);

    always_comb begin
        n_side           = '0;
        n_side.btn       = r_s1_btn;
        n_side.center    = w_tdz ? '0 : r_s1_tfs[FRAC+7:FRAC];
        n_side.twist_rev = !w_tdz && r_s1_tneg;
        n_side.y_pos     = (r_s1_y > 0);
        n_side.fwd_left  = w_fwd_left;
        n_side.sec_right = w_p5 && !w_p7;
        n_side.sec_both  = !(w_p5 && !w_p7) && w_p3 && !w_p5;
        n_side.sec_left  = !(w_p5 && !w_p7) && !(w_p3 && !w_p5) && w_p1 && !w_p3;
    end

    logic           r_s2_vld;
    logic [2*N-1:0] r_s2_sum;
    logic [N-1:0]   r_s2_fac;
    t_side          r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
        if (w_en) begin
            r_s2_sum  <= unsigned'(r_s1_xx) + unsigned'(r_s1_yy);
            r_s2_fac  <= w_fac_s[N-1:0];
            r_s2_side <= n_side;
        end
    end

    // Square root of the radius squared, one bit per stage.
    logic           w_sq_vld;
    logic [N-1:0]   w_sq_root;
    logic [N+SW-1:0] w_sq_side;
    logic [N-1:0]   w_sq_fac;
    t_side          w_sq_sd;

    jddm_isqrt #(
        .N      (N),
        .SIDE_W (N + SW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_vld),
        .i_rad   (r_s2_sum),
        .i_side  ({r_s2_fac, r_s2_side}),
        .o_valid (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    assign w_sq_fac = w_sq_side[N+SW-1:SW];
    assign w_sq_sd  = t_side'(w_sq_side[SW-1:0]);

    // Stage A: clamp the radius to one and apply the stick dead zone.
    logic [N-1:0] w_r;
    assign w_r = (w_sq_root > ONE) ? ONE : w_sq_root;

    logic         r_a_vld;
    logic [N-1:0] r_a_r;
    logic [N-1:0] r_a_fac;
    logic         r_a_dz;
    t_side        r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= w_sq_vld;
        end
        if (w_en) begin
            r_a_r    <= w_r;
            r_a_fac  <= w_sq_fac;
            r_a_dz   <= ({w_r, {DZ_SHIFT{1'b0}}}) < ((N + DZ_SHIFT)'(r_stick_dz) << FRAC);
            r_a_side <= w_sq_sd;
        end
    end

    // Stage B: radius times full scale, and radius times the forward factor.
    logic           r_b_vld;
    logic [N+7:0]   r_b_rfs;
    logic [2*N-1:0] r_b_rf;
    logic           r_b_dz;
    t_side          r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
        if (w_en) begin
            r_b_rfs  <= r_a_r * r_full_scale;
            r_b_rf   <= r_a_r * r_a_fac;
            r_b_dz   <= r_a_dz;
            r_b_side <= r_a_side;
        end
    end

    // Stage C: the forward product is scaled to full scale and the radius speed is sliced out.
    logic           r_c_vld;
    logic [SPD_W-1:0] r_c_sr;
    logic [2*N+7:0] r_c_rffs;
    logic           r_c_dz;
    t_side          r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
        if (w_en) begin
            r_c_sr   <= r_b_rfs[FRAC+7:FRAC];
            r_c_rffs <= r_b_rf * r_full_scale;
            r_c_dz   <= r_b_dz;
            r_c_side <= r_b_side;
        end
    end

    // Output stage: buttons, dead zone and sector choose the final result.
    logic [SPD_W-1:0]  w_s2;
    logic [SPD_W-1:0]  n_left;
    logic [SPD_W-1:0]  n_right;
    logic [SPD_W-1:0]  n_center;
    logic [MASK_W-1:0] n_mask;
    logic              n_quit;

    assign w_s2 = r_c_rffs[2*FRAC+7:2*FRAC];

    always_comb begin
        n_left            = '0;
        n_right           = '0;
        n_center          = r_c_side.center;
        n_mask            = r_c_side.btn[MASK_W-1:0];
        n_mask[MB_ONE]    = 1'b1;
        n_mask[MB_CENTER] = r_c_side.twist_rev;
        n_quit            = 1'b0;

        if (r_c_side.btn[BTN_SPIN_L]) begin
            n_left           = r_full_scale;
            n_right          = r_full_scale;
            n_mask[MB_LEFT]  = 1'b1;
            n_mask[MB_RIGHT] = 1'b0;
        end else if (r_c_side.btn[BTN_SPIN_R]) begin
            n_left           = r_full_scale;
            n_right          = r_full_scale;
            n_mask[MB_LEFT]  = 1'b0;
            n_mask[MB_RIGHT] = 1'b1;
        end else begin
            if (r_c_side.btn[BTN_FLAG]) begin
                n_mask[MB_FLAG] = 1'b1;
            end
            if (r_c_dz) begin
                n_mask[MB_LEFT]  = 1'b0;
                n_mask[MB_RIGHT] = 1'b0;
            end else if (!r_c_side.y_pos) begin
                // Forward half: the outer wheel runs at the radius, the inner one slows.
                n_left           = r_c_side.fwd_left ? r_c_sr : w_s2;
                n_right          = r_c_side.fwd_left ? w_s2 : r_c_sr;
                n_mask[MB_LEFT]  = 1'b0;
                n_mask[MB_RIGHT] = 1'b0;
            end else if (r_c_side.sec_right) begin
                n_right          = r_c_sr;
                n_mask[MB_LEFT]  = 1'b0;
                n_mask[MB_RIGHT] = 1'b1;
            end else if (r_c_side.sec_both) begin
                n_left           = r_c_sr;
                n_right          = r_c_sr;
                n_mask[MB_LEFT]  = 1'b1;
                n_mask[MB_RIGHT] = 1'b1;
            end else if (r_c_side.sec_left) begin
                n_left           = r_c_sr;
                n_mask[MB_LEFT]  = 1'b1;
                n_mask[MB_RIGHT] = 1'b0;
            end
            // Outside the covered sectors both drives stop and the reverse bits pass.
        end

        if (r_c_side.btn[BTN_QUIT]) begin
            n_left   = '0;
            n_right  = '0;
            n_center = '0;
            n_mask   = '0;
            n_quit   = 1'b1;
        end
    end

    logic              r_o_vld;
    logic [SPD_W-1:0]  r_o_left;
    logic [SPD_W-1:0]  r_o_right;
    logic [SPD_W-1:0]  r_o_center;
    logic [MASK_W-1:0] r_o_mask;
    logic              r_o_quit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= r_c_vld;
        end
        if (w_en) begin
            r_o_left   <= n_left;
            r_o_right  <= n_right;
            r_o_center <= n_center;
            r_o_mask   <= n_mask;
            r_o_quit   <= n_quit;
        end
    end

    assign o_mix.valid          = r_o_vld;
    assign o_mix.left_speed     = r_o_left;
    assign o_mix.right_speed    = r_o_right;
    assign o_mix.center_speed   = r_o_center;
    assign o_mix.direction_mask = r_o_mask;
    assign o_mix.quit           = r_o_quit;

endmodule

@@ hdl/jddm_checker.sv @@
module jddm_checker
    import jddm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [SPD_W-1:0]  i_left,
    input logic [SPD_W-1:0]  i_right,
    input logic [SPD_W-1:0]  i_center,
    input logic [MASK_W-1:0] i_mask,
    input logic              i_quit
);

    // A quit result carries no drive at all.
    a_quit_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_quit |-> i_left == '0 && i_right == '0 && i_center == '0
                                  && i_mask == '0)
        else $error("quit result with nonzero drive");

    // Every other result has the constant-one mask bit set.
    a_mask_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_quit |-> i_mask[MB_ONE])
        else $error("mask bit zero missing");

    // The input side only waits while a finished result is held.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input stalled without output backpressure");

    // A held result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_left) && $stable(i_right)
                                        && $stable(i_center) && $stable(i_mask)
                                        && $stable(i_quit))
        else $error("held result changed");

endmodule

bind joystick_differential_drive_mixer jddm_checker u_jddm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rpt.ready),
    .i_out_valid (o_mix.valid),
    .i_out_ready (o_mix.ready),
    .i_left      (o_mix.left_speed),
    .i_right     (o_mix.right_speed),
    .i_center    (o_mix.center_speed),
    .i_mask      (o_mix.direction_mask),
    .i_quit      (o_mix.quit)
);
